FILE: sv/rv32i_execute_unit_assert.svh
// Assertion shorthands used by the bound checker.
`ifndef RV32I_EXECUTE_UNIT_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define RVEX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rvex assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define RVEX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rvex assertion failed");

`endif

FILE: sv/rvex_pkg.sv
package rvex_pkg;

  localparam int Xlen     = 32;
  localparam int RegCount = 32;
  localparam int RegAddrW = $clog2(RegCount);
  localparam int ShamtW   = 5;

  // major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6f;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // load / store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SW  = 3'd2;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;

  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] BYTES_1 = 3'd1;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_4 = 3'd4;

  typedef enum logic {
    ITEM_EXEC      = 1'b0,
    ITEM_LOAD_DATA = 1'b1
  } item_op_e;

  typedef struct packed {
    item_op_e          opcode;
    logic [Xlen-1:0]   instruction;
    logic [Xlen-1:0]   load_data;
  } in_item_t;

  typedef struct packed {
    logic [Xlen-1:0] next_pc;
    logic            rd_write;
    logic [4:0]      rd_index;
    logic [Xlen-1:0] rd_value;
    logic            mem_request;
    logic            mem_is_write;
    logic [Xlen-1:0] mem_address;
    logic [Xlen-1:0] mem_write_data;
    logic [2:0]      mem_bytes;
    logic            waiting_for_load;
    logic            halted;
    logic            illegal;
  } out_item_t;

  // register number exists in this register file
  function automatic logic reg_ok(logic [4:0] idx);
    return {1'b0, idx} < 6'(RegCount);
  endfunction

endpackage

FILE: sv/rvex_in_if.sv
interface rvex_in_if;
  logic               valid;
  logic               ready;
  rvex_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rvex_out_if.sv
interface rvex_out_if;
  logic                valid;
  logic                ready;
  rvex_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rvex_ram.sv
module rvex_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // one write port, two registered read ports (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/rvex_alu.sv
module rvex_alu (
  input  logic [2:0]                f3_i,
  input  logic                      alt_i,
  input  logic [rvex_pkg::Xlen-1:0] a_i,
  input  logic [rvex_pkg::Xlen-1:0] b_i,
  output logic [rvex_pkg::Xlen-1:0] res_o
);
  import rvex_pkg::*;

  logic [ShamtW-1:0] shamt;

  assign shamt = b_i[ShamtW-1:0];

  // integer operation selected by funct3; alt picks SUB / SRA
  always_comb begin
    unique case (f3_i)
      F3_ADD:  res_o = alt_i ? a_i - b_i : a_i + b_i;
      F3_SLL:  res_o = a_i << shamt;
      F3_SLT:  res_o = Xlen'($signed(a_i) < $signed(b_i));
      F3_SLTU: res_o = Xlen'(a_i < b_i);
      F3_XOR:  res_o = a_i ^ b_i;
      F3_SR:   res_o = alt_i ? $unsigned($signed(a_i) >>> shamt) : a_i >> shamt;
      F3_OR:   res_o = a_i | b_i;
      default: res_o = a_i & b_i;
    endcase
  end

endmodule

FILE: sv/rv32i_execute_unit.sv
// RV32I execute unit.
// in_i carries transactions of two kinds: an instruction word to execute at
// the current pc, or the read data answering the last load request. out_o
// returns exactly one result transaction per input transaction, in order:
// next pc, register write, memory request, load-wait and halt status, and
// an illegal flag for rejected transactions.
// cfg_we_i/cfg_wdata_i load a new start pc into the pc; the user must write it only while
// the unit idles, the block itself does not enforce this. An accepted input is loaded
// into the input stage, then, when it fires, its result into the result register.
// Throughput: one transaction per cycle while out_o takes results; the limiting
// path is decode, ALU and the next-pc adder between the input stage and the
// result register, with the register file write forwarded to the read of the
// following transaction.
// Reset: pc is 0, no load pending, not halted; every register reads zero
// through per-entry valid bits, so no clearing pass is needed.
// Stall: when out_o is not taken the result holds, one further transaction
// may wait in the input stage, and then in_i.ready drops.
module rv32i_execute_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rvex_pkg::Xlen-1:0] cfg_wdata_i,
  rvex_in_if.sink                   in_i,
  rvex_out_if.source                out_o
);
  import rvex_pkg::*;

  // input stage
  logic                s1_valid_q;
  in_item_t            s1_item_q;
  logic                a_fwd_q, b_fwd_q, a_zero_q, b_zero_q;
  logic [Xlen-1:0]     fwd_val_q;
  logic [Xlen-1:0]     ram_a, ram_b;

  // architectural state
  logic [Xlen-1:0]     pc_q, pc_d;
  logic                pend_q, pend_d;
  logic [4:0]          ld_dest_q, ld_dest_d;
  logic [2:0]          ld_kind_q, ld_kind_d;
  logic                halt_q, halt_d;
  logic [RegCount-1:0] rf_valid_q;

  // result register
  logic                out_valid_q;
  out_item_t           out_q;

  logic fire, in_acc;

  // decode fields
  logic [Xlen-1:0] ins, a, b;
  logic [6:0]      op, f7;
  logic [2:0]      f3;
  logic [4:0]      rd, rs1, rs2;
  logic [Xlen-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [Xlen-1:0] alu_b, alu_res, ld_val;
  logic            alu_alt, take;

  logic            wr, req, isw, bad, wr_en;
  logic [4:0]      rdi, rd_out;
  logic [Xlen-1:0] wval, wval_out, addr, wdata;
  logic [2:0]      bytes;

  logic [4:0]      rs1_in, rs2_in;
  logic            a_fwd_d, b_fwd_d, a_zero_d, b_zero_d;

  assign fire       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || fire;
  assign in_acc     = in_i.valid && in_i.ready;

  // operands: forwarded write, zero, or register file data
  assign a = a_zero_q ? '0 : (a_fwd_q ? fwd_val_q : ram_a);
  assign b = b_zero_q ? '0 : (b_fwd_q ? fwd_val_q : ram_b);

  assign ins = s1_item_q.instruction;
  assign op  = ins[6:0];
  assign rd  = ins[11:7];
  assign f3  = ins[14:12];
  assign rs1 = ins[19:15];
  assign rs2 = ins[24:20];
  assign f7  = ins[31:25];

  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};

  assign alu_b   = (op == OPC_OP) ? b : imm_i;
  assign alu_alt = (op == OPC_OP) ? (f7 == F7_ALT) : (f3 == F3_SR && f7 == F7_ALT);

  rvex_alu u_alu (
    .f3_i  (f3),
    .alt_i (alu_alt),
    .a_i   (a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // branch condition
  always_comb begin
    unique case (f3)
      F3_BEQ:  take = (a == b);
      F3_BNE:  take = (a != b);
      F3_BLT:  take = $signed(a) < $signed(b);
      F3_BGE:  take = $signed(a) >= $signed(b);
      F3_BLTU: take = (a < b);
      default: take = (a >= b);
    endcase
  end

  // load data extension by the recorded funct3
  always_comb begin
    unique case (ld_kind_q)
      F3_LB:   ld_val = {{24{s1_item_q.load_data[7]}}, s1_item_q.load_data[7:0]};
      F3_LH:   ld_val = {{16{s1_item_q.load_data[15]}}, s1_item_q.load_data[15:0]};
      F3_LBU:  ld_val = {24'b0, s1_item_q.load_data[7:0]};
      F3_LHU:  ld_val = {16'b0, s1_item_q.load_data[15:0]};
      default: ld_val = s1_item_q.load_data;
    endcase
  end

  // execute one transaction
  always_comb begin
    pc_d      = pc_q + 32'd4;
    pend_d    = pend_q;
    ld_dest_d = ld_dest_q;
    ld_kind_d = ld_kind_q;
    halt_d    = halt_q;
    wr        = 1'b0;
    req       = 1'b0;
    isw       = 1'b0;
    bad       = 1'b0;
    rdi       = rd;
    wval      = '0;
    addr      = '0;
    wdata     = '0;
    bytes     = '0;

    if (halt_q) begin
      pc_d = pc_q;
    end else if (s1_item_q.opcode == ITEM_LOAD_DATA) begin
      pc_d = pc_q;
      if (!pend_q) begin
        bad = 1'b1;
      end else begin
        rdi    = ld_dest_q;
        wr     = 1'b1;
        wval   = ld_val;
        pend_d = 1'b0;
      end
    end else if (pend_q) begin
      // instruction while a load waits: rejected, pc still advances
      bad = 1'b1;
    end else begin
      unique case (op) inside
        OPC_OP_IMM: begin
          bad  = !reg_ok(rd) || !reg_ok(rs1);
          wr   = 1'b1;
          wval = alu_res;
        end
        OPC_OP: begin
          bad  = !reg_ok(rd) || !reg_ok(rs1) || !reg_ok(rs2);
          wr   = 1'b1;
          wval = alu_res;
        end
        OPC_LOAD: begin
          bad  = !reg_ok(rd) || !reg_ok(rs1) || f3 == F3_SLTU || f3 > F3_LHU;
          req  = 1'b1;
          addr = a + imm_i;
          unique case (f3[1:0])
            2'd0:    bytes = BYTES_1;
            2'd1:    bytes = BYTES_2;
            default: bytes = BYTES_4;
          endcase
        end
        OPC_STORE: begin
          bad   = !reg_ok(rs1) || !reg_ok(rs2) || f3 > F3_SW;
          req   = 1'b1;
          isw   = 1'b1;
          addr  = a + imm_s;
          wdata = b;
          unique case (f3)
            F3_LB:   bytes = BYTES_1;
            F3_LH:   bytes = BYTES_2;
            default: bytes = BYTES_4;
          endcase
        end
        OPC_BRANCH: begin
          bad = !reg_ok(rs1) || !reg_ok(rs2) || f3 == F3_SLT || f3 == F3_SLTU;
          if (take) begin
            pc_d = pc_q + imm_b;
          end
        end
        OPC_JALR: begin
          bad  = !reg_ok(rd) || !reg_ok(rs1) || f3 != F3_JALR;
          wr   = 1'b1;
          wval = pc_q + 32'd4;
          pc_d = (a + imm_i) & ~32'd1;
        end
        OPC_JAL: begin
          bad  = !reg_ok(rd);
          wr   = 1'b1;
          wval = pc_q + 32'd4;
          pc_d = pc_q + imm_j;
        end
        OPC_LUI: begin
          bad  = !reg_ok(rd);
          wr   = 1'b1;
          wval = imm_u;
        end
        OPC_AUIPC: begin
          bad  = !reg_ok(rd);
          wr   = 1'b1;
          wval = pc_q + imm_u;
        end
        OPC_MISC_MEM, OPC_SYSTEM: begin
        end
        default: bad = 1'b1;
      endcase

      if (bad) begin
        wr    = 1'b0;
        req   = 1'b0;
        isw   = 1'b0;
        pc_d  = pc_q;
        wval  = '0;
        addr  = '0;
        wdata = '0;
        bytes = '0;
      end else begin
        if (req && !isw) begin
          pend_d    = 1'b1;
          ld_dest_d = rd;
          ld_kind_d = f3;
        end
        if (op == OPC_JALR && pc_d == '0) begin
          halt_d = 1'b1;
        end
      end
    end
  end

  // x0 and absent registers are never written
  assign wr_en    = fire && wr && rdi != 5'd0 && reg_ok(rdi);
  assign rd_out   = (wr && rdi != 5'd0 && reg_ok(rdi)) ? rdi : 5'd0;
  assign wval_out = (rd_out != 5'd0) ? wval : '0;

  // register file read for the incoming transaction, with bypass
  assign rs1_in   = in_i.data.instruction[19:15];
  assign rs2_in   = in_i.data.instruction[24:20];
  assign a_fwd_d  = wr_en && rd_out == rs1_in;
  assign b_fwd_d  = wr_en && rd_out == rs2_in;
  assign a_zero_d = !a_fwd_d && (rs1_in == 5'd0 || !reg_ok(rs1_in) ||
                                 !rf_valid_q[rs1_in[RegAddrW-1:0]]);
  assign b_zero_d = !b_fwd_d && (rs2_in == 5'd0 || !reg_ok(rs2_in) ||
                                 !rf_valid_q[rs2_in[RegAddrW-1:0]]);

  rvex_ram #(
    .Width (Xlen),
    .Depth (RegCount)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (rd_out[RegAddrW-1:0]),
    .wdata_i   (wval_out),
    .re_i      (in_acc),
    .raddr_a_i (rs1_in[RegAddrW-1:0]),
    .raddr_b_i (rs2_in[RegAddrW-1:0]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      pend_q      <= 1'b0;
      ld_dest_q   <= '0;
      ld_kind_q   <= '0;
      halt_q      <= 1'b0;
      rf_valid_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end else if (fire) begin
        pc_q <= pc_d;
      end
      if (fire) begin
        pend_q    <= pend_d;
        ld_dest_q <= ld_dest_d;
        ld_kind_q <= ld_kind_d;
        halt_q    <= halt_d;
      end
      if (wr_en) begin
        rf_valid_q[rd_out[RegAddrW-1:0]] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_i.data;
      a_fwd_q   <= a_fwd_d;
      b_fwd_q   <= b_fwd_d;
      a_zero_q  <= a_zero_d;
      b_zero_q  <= b_zero_d;
      fwd_val_q <= wval_out;
    end
    if (fire) begin
      out_q.next_pc          <= pc_d;
      out_q.rd_write         <= rd_out != 5'd0;
      out_q.rd_index         <= rd_out;
      out_q.rd_value         <= wval_out;
      out_q.mem_request      <= req;
      out_q.mem_is_write     <= isw;
      out_q.mem_address      <= addr;
      out_q.mem_write_data   <= wdata;
      out_q.mem_bytes        <= bytes;
      out_q.waiting_for_load <= pend_d;
      out_q.halted           <= halt_d;
      out_q.illegal          <= bad;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: sv/rvex_checker.sv
`include "rv32i_execute_unit_assert.svh"

module rvex_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input rvex_pkg::out_item_t out_data_i
);
  import rvex_pkg::*;

  // a stalled result stays put
  `RVEX_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // a rejected transaction writes nothing and requests nothing
  `RVEX_ASSERT_IMP(a_illegal_quiet, clk_i, rst_ni, out_valid_i && out_data_i.illegal, !out_data_i.rd_write && !out_data_i.mem_request)

  // x0 is never reported as written; no write means zero index and value
  `RVEX_ASSERT_IMP(a_rd_shape, clk_i, rst_ni, out_valid_i, out_data_i.rd_write ? (out_data_i.rd_index != 5'd0) : (out_data_i.rd_index == 5'd0 && out_data_i.rd_value == '0))

  // memory fields are clear without a request
  `RVEX_ASSERT_IMP(a_mem_idle, clk_i, rst_ni, out_valid_i && !out_data_i.mem_request, !out_data_i.mem_is_write && out_data_i.mem_bytes == 3'd0 && out_data_i.mem_address == '0)

  // halt never clears once reported
  `RVEX_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, out_valid_i && out_data_i.halted, !out_valid_i || out_data_i.halted)

endmodule

bind rv32i_execute_unit rvex_checker u_rvex_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: tb/rv32i_execute_unit_checker.sv
// Watches both channels of the execute unit, keeps its own copy of the
// architectural state and compares every result transaction in order.
module rv32i_execute_unit_checker
  import rvex_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [Xlen-1:0] cfg_wdata_i,
  rvex_in_if              in_mon,
  rvex_out_if             out_mon,
  output int              mismatches_o,
  output int              outstanding_o
);

  // funct3 codes the package leaves out
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;

  // shadow architectural state
  logic [Xlen-1:0] gpr [RegCount];
  logic [Xlen-1:0] start_pc_q;
  logic [Xlen-1:0] pc_q;
  logic            load_waiting;
  logic [4:0]      load_rd;
  logic [2:0]      load_f3;
  logic            halt_seen;

  out_item_t results_q [$];

  function automatic logic reg_exists(logic [4:0] idx);
    return int'(idx) < RegCount;
  endfunction

  // x0 and absent registers read as zero
  function automatic logic [Xlen-1:0] read_gpr(logic [4:0] idx);
    if (idx == 5'd0 || !reg_exists(idx)) return '0;
    return gpr[idx];
  endfunction

  function automatic logic [Xlen-1:0] alu_result(logic [2:0] f3, logic alt,
                                                 logic [Xlen-1:0] a, logic [Xlen-1:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[ShamtW-1:0];
      F3_SLT:  return ($signed(a) < $signed(b)) ? Xlen'(1) : Xlen'(0);
      F3_SLTU: return (a < b) ? Xlen'(1) : Xlen'(0);
      F3_XOR:  return a ^ b;
      F3_SR: begin
        if (alt) return $signed(a) >>> b[ShamtW-1:0];
        return a >> b[ShamtW-1:0];
      end
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one input transaction on the shadow state, returns its result
  function automatic out_item_t execute_transaction(in_item_t it);
    logic [Xlen-1:0] ins, a, b, npc, immi, wval, addr, wdata, off, ld;
    logic [6:0]      opc;
    logic [2:0]      f3, nbytes;
    logic [4:0]      rd, rs1, rs2;
    logic            wr, req, isw, bad, take;
    out_item_t       res;
    ins    = it.instruction;
    opc    = ins[6:0];
    f3     = ins[14:12];
    rd     = ins[11:7];
    rs1    = ins[19:15];
    rs2    = ins[24:20];
    a      = read_gpr(rs1);
    b      = read_gpr(rs2);
    npc    = pc_q + Xlen'(4);
    immi   = {{20{ins[31]}}, ins[31:20]};
    wr     = 1'b0;
    req    = 1'b0;
    isw    = 1'b0;
    bad    = 1'b0;
    wval   = '0;
    addr   = '0;
    wdata  = '0;
    nbytes = '0;

    if (halt_seen) begin
      npc = pc_q;
    end else if (it.opcode == ITEM_LOAD_DATA) begin
      npc = pc_q;
      if (!load_waiting) begin
        bad = 1'b1;
      end else begin
        ld = it.load_data;
        case (load_f3)
          F3_LB:   ld = {{24{ld[7]}}, ld[7:0]};
          F3_LH:   ld = {{16{ld[15]}}, ld[15:0]};
          F3_LBU:  ld = {24'd0, ld[7:0]};
          F3_LHU:  ld = {16'd0, ld[15:0]};
          default: ;
        endcase
        rd           = load_rd;
        wr           = 1'b1;
        wval         = ld;
        load_waiting = 1'b0;
      end
    end else if (load_waiting) begin
      bad = 1'b1;
    end else begin
      case (opc)
        OPC_OP_IMM: begin
          bad  = !reg_exists(rd) || !reg_exists(rs1);
          wr   = 1'b1;
          wval = alu_result(f3, f3 == F3_SR && ins[31:25] == F7_ALT, a, immi);
        end
        OPC_OP: begin
          bad  = !reg_exists(rd) || !reg_exists(rs1) || !reg_exists(rs2);
          wr   = 1'b1;
          wval = alu_result(f3, ins[31:25] == F7_ALT, a, b);
        end
        OPC_LOAD: begin
          bad    = !reg_exists(rd) || !reg_exists(rs1) ||
                   !(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU});
          req    = 1'b1;
          addr   = a + immi;
          nbytes = (f3[1:0] == F3_LB[1:0]) ? BYTES_1 :
                   (f3[1:0] == F3_LH[1:0]) ? BYTES_2 : BYTES_4;
        end
        OPC_STORE: begin
          bad    = !reg_exists(rs1) || !reg_exists(rs2) || f3 > F3_SW;
          req    = 1'b1;
          isw    = 1'b1;
          addr   = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
          wdata  = b;
          nbytes = (f3 == F3_SB) ? BYTES_1 : (f3 == F3_SH) ? BYTES_2 : BYTES_4;
        end
        OPC_BRANCH: begin
          off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          bad = !reg_exists(rs1) || !reg_exists(rs2) ||
                !(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU});
          case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = $signed(a) < $signed(b);
            F3_BGE:  take = $signed(a) >= $signed(b);
            F3_BLTU: take = a < b;
            default: take = a >= b;
          endcase
          if (take) npc = pc_q + off;
        end
        OPC_JALR: begin
          bad  = !reg_exists(rd) || !reg_exists(rs1) || f3 != F3_JALR;
          wr   = 1'b1;
          wval = pc_q + Xlen'(4);
          npc  = (a + immi) & ~Xlen'(1);
        end
        OPC_JAL: begin
          bad  = !reg_exists(rd);
          wr   = 1'b1;
          wval = pc_q + Xlen'(4);
          off  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          npc  = pc_q + off;
        end
        OPC_LUI: begin
          bad  = !reg_exists(rd);
          wr   = 1'b1;
          wval = {ins[31:12], 12'd0};
        end
        OPC_AUIPC: begin
          bad  = !reg_exists(rd);
          wr   = 1'b1;
          wval = pc_q + {ins[31:12], 12'd0};
        end
        OPC_MISC_MEM, OPC_SYSTEM: ;
        default: bad = 1'b1;
      endcase

      // rejected instruction leaves no trace
      if (bad) begin
        wr     = 1'b0;
        req    = 1'b0;
        isw    = 1'b0;
        npc    = pc_q;
        wval   = '0;
        addr   = '0;
        wdata  = '0;
        nbytes = '0;
      end else begin
        if (req && !isw) begin
          load_waiting = 1'b1;
          load_rd      = rd;
          load_f3      = f3;
        end
        if (opc == OPC_JALR && npc == '0) halt_seen = 1'b1;
      end
    end

    // register write, x0 discarded
    if (wr && (rd == 5'd0 || !reg_exists(rd))) wr = 1'b0;
    if (wr) begin
      gpr[rd] = wval;
    end else begin
      rd   = '0;
      wval = '0;
    end
    pc_q = npc;

    res.next_pc          = npc;
    res.rd_write         = wr;
    res.rd_index         = rd;
    res.rd_value         = wval;
    res.mem_request      = req;
    res.mem_is_write     = isw;
    res.mem_address      = addr;
    res.mem_write_data   = wdata;
    res.mem_bytes        = nbytes;
    res.waiting_for_load = load_waiting;
    res.halted           = halt_seen;
    res.illegal          = bad;
    return res;
  endfunction

  function automatic void check_field(string field, logic [Xlen-1:0] want,
                                      logic [Xlen-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      mismatches_o++;
    end
  endfunction

  // Track configuration, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t got, want;
    if (!rst_ni) begin
      foreach (gpr[i]) gpr[i] = '0;
      start_pc_q    = '0;
      pc_q          = '0;
      load_waiting  = 1'b0;
      load_rd       = '0;
      load_f3       = '0;
      halt_seen     = 1'b0;
      results_q.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        start_pc_q = cfg_wdata_i;
        pc_q       = cfg_wdata_i;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (results_q.size() == 0) begin
          $error("result transaction with nothing expected, next_pc %h", got.next_pc);
          mismatches_o++;
        end else begin
          want = results_q.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("rd_write", want.rd_write, got.rd_write);
          check_field("rd_index", want.rd_index, got.rd_index);
          check_field("rd_value", want.rd_value, got.rd_value);
          check_field("mem_request", want.mem_request, got.mem_request);
          check_field("mem_is_write", want.mem_is_write, got.mem_is_write);
          check_field("mem_address", want.mem_address, got.mem_address);
          check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
          check_field("mem_bytes", want.mem_bytes, got.mem_bytes);
          check_field("waiting_for_load", want.waiting_for_load, got.waiting_for_load);
          check_field("halted", want.halted, got.halted);
          check_field("illegal", want.illegal, got.illegal);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        results_q.push_back(execute_transaction(in_mon.data));
      end
      outstanding_o = results_q.size();
    end
  end

endmodule

FILE: tb/rv32i_execute_unit_test.sv
// Drives instruction and load-data transactions into the execute unit under
// several idling mixes and start pc settings; the checker does the scoring.
module rv32i_execute_unit_test;
  import rvex_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int HOLD_OFF_CYCLES  = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 340;

  // reserved funct3 values used to provoke rejects
  localparam logic [2:0] F3_LOAD_RSV = 3'd3;
  localparam logic [2:0] F3_JALR_RSV = 3'd1;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [Xlen-1:0] cfg_wdata_i;

  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;
  bit load_owed;
  int mismatches;
  int outstanding;

  logic [2:0] load_kinds [5] = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};

  rvex_in_if  in_ch ();
  rvex_out_if out_ch ();

  rv32i_execute_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  rv32i_execute_unit_checker exec_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [6:0] opc);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [6:0] opc);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], opc};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] upper, logic [4:0] rd, logic [6:0] opc);
    return {upper, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd, logic [6:0] opc);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, opc};
  endfunction

  function automatic logic starts_load(logic [31:0] ins);
    return ins[6:0] == OPC_LOAD &&
           (ins[14:12] inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU});
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // instruction transaction; notes when it opens a load
  task automatic send_exec(input logic [31:0] ins);
    in_item_t it;
    it.opcode      = ITEM_EXEC;
    it.instruction = ins;
    it.load_data   = $urandom();
    if (!load_owed && starts_load(ins)) load_owed = 1'b1;
    send_item(it);
  endtask

  task automatic send_data(input logic [31:0] value);
    in_item_t it;
    it.opcode      = ITEM_LOAD_DATA;
    it.instruction = $urandom();
    it.load_data   = value;
    load_owed      = 1'b0;
    send_item(it);
  endtask

  // Stop offering and let every expected result come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [Xlen-1:0] pc_value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pc_value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
  endtask

  // LUI of a nonzero upper part then JALR through it: never lands on zero
  task automatic far_jump();
    logic [4:0]  rs;
    logic [19:0] upper;
    rs    = 5'($urandom_range(31, 1));
    upper = 20'($urandom);
    if (upper == '0) upper[0] = 1'b1;
    send_exec(enc_u(upper, rs, OPC_LUI));
    send_exec(enc_i(12'($urandom), rs, F3_JALR, 5'($urandom), OPC_JALR));
  endtask

  task automatic random_instruction();
    logic [31:0] w;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    int          pick;
    rd   = 5'($urandom);
    rs1  = 5'($urandom);
    rs2  = 5'($urandom);
    f3   = 3'($urandom);
    imm  = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 24) begin
      if (f3 == F3_SR && $urandom_range(1) == 1) imm[11:5] = F7_ALT;
      send_exec(enc_i(imm, rs1, f3, rd, OPC_OP_IMM));
    end else if (pick < 44) begin
      case ($urandom_range(2))
        0:       f7 = '0;
        1:       f7 = F7_ALT;
        default: f7 = 7'($urandom);
      endcase
      send_exec(enc_r(f7, rs2, rs1, f3, rd, OPC_OP));
    end else if (pick < 58) begin
      if ($urandom_range(7) != 0) f3 = load_kinds[$urandom_range(4)];
      send_exec(enc_i(imm, rs1, f3, rd, OPC_LOAD));
    end else if (pick < 68) begin
      if ($urandom_range(3) != 0) f3 = 3'($urandom_range(2));
      send_exec(enc_s(imm, rs2, rs1, f3, OPC_STORE));
    end else if (pick < 78) begin
      if ($urandom_range(3) == 0) rs2 = rs1;
      send_exec(enc_b(13'($urandom), rs2, rs1, f3, OPC_BRANCH));
    end else if (pick < 83) begin
      send_exec(enc_j(21'($urandom), rd, OPC_JAL));
    end else if (pick < 88) begin
      send_exec(enc_u(20'($urandom), rd, ($urandom_range(1) == 1) ? OPC_LUI : OPC_AUIPC));
    end else if (pick < 91) begin
      far_jump();
    end else if (pick < 93) begin
      // reserved funct3 is rejected before any halt decision
      if (f3 == F3_JALR) f3 = F3_JALR_RSV;
      send_exec(enc_i(imm, rs1, f3, rd, OPC_JALR));
    end else if (pick < 96) begin
      w      = $urandom();
      w[6:0] = ($urandom_range(1) == 1) ? OPC_MISC_MEM : OPC_SYSTEM;
      send_exec(w);
    end else if (pick < 98) begin
      // raw word; steer clear of a JALR that could halt
      w = $urandom();
      if (w[6:0] == OPC_JALR) w[3] = ~w[3];
      send_exec(w);
    end else begin
      send_data($urandom());
    end
  endtask

  // Mostly well-formed: an open load is usually answered next
  task automatic random_program(input int count);
    for (int n = 0; n < count; n++) begin
      if (load_owed && $urandom_range(9) != 0) send_data($urandom());
      else random_instruction();
    end
  endtask

  task automatic directed_sequence();
    send_exec(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_OP_IMM));   // most negative imm
    send_exec(enc_u(20'h80000, 5'd3, OPC_LUI));
    send_exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd4, OPC_OP_IMM));   // all ones
    // every register-register funct3 (with SUB and SRA) on the extreme operands
    for (int k = 0; k < 8; k++) begin
      send_exec(enc_r((3'(k) inside {F3_ADD, F3_SR}) ? F7_ALT : 7'd0, 5'd4, 5'd3, 3'(k),
                      5'(10 + k), OPC_OP));
    end
    send_exec(enc_i(12'd5, 5'd4, F3_ADD, 5'd0, OPC_OP_IMM));     // write to x0 dropped
    send_exec(enc_i(12'hfff, 5'd3, F3_LB, 5'd6, OPC_LOAD));
    send_data(32'h1234_5680);                                    // sign extended byte
    send_exec(enc_i(12'd0, 5'd1, F3_LHU, 5'd7, OPC_LOAD));
    send_data(32'hffff_8000);                                    // zero extended half
    send_exec(enc_i(12'h7ff, 5'd1, F3_LW, 5'd0, OPC_LOAD));      // load to x0
    send_exec(32'h0000_0073);                                    // instruction while pending
    send_data(32'hdead_beef);
    send_exec(enc_s(12'h7ff, 5'd4, 5'd1, F3_SW, OPC_STORE));
    send_exec(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ, OPC_BRANCH)); // furthest back, taken
    send_exec(enc_j(21'h10_0000, 5'd1, OPC_JAL));
    send_exec(enc_i(12'd0, 5'd4, F3_JALR, 5'd9, OPC_JALR));     // target bit 0 cleared
    send_exec(enc_u(20'hfffff, 5'd10, OPC_AUIPC));
    send_exec(enc_i(12'($urandom), 5'd0, 3'($urandom), 5'd0, OPC_MISC_MEM));
    send_exec(32'h0000_0000);                                    // unknown opcode
    send_exec(enc_i(12'd0, 5'd1, F3_LOAD_RSV, 5'd2, OPC_LOAD));
    send_exec(enc_i(12'd0, 5'd0, F3_JALR_RSV, 5'd1, OPC_JALR)); // rejected, no halt
    send_data(32'h0000_00ff);                                    // data with no load open
  endtask

  // Halt is final: JALR to address zero, then transactions that are ignored
  task automatic halt_sequence();
    if (load_owed) send_data($urandom());
    send_exec(enc_i(12'd1, 5'd0, F3_JALR, 5'd1, OPC_JALR));
    repeat (3) send_exec($urandom());
    send_data($urandom());
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    hold_off_req  = 1'b0;
    load_owed     = 1'b0;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(32'hffff_fff0);
    directed_sequence();

    configure(32'hffff_ffff);
    random_program(100);
    hold_off_req = 1'b1;
    random_program(RANDOM_PER_PHASE - 100);

    configure(32'h0000_0000);
    set_idling(77, 0);
    random_program(RANDOM_PER_PHASE);

    configure($urandom());
    set_idling(0, 77);
    random_program(RANDOM_PER_PHASE);

    configure(32'h8000_0000);
    set_idling(8, 8);
    random_program(RANDOM_PER_PHASE);
    halt_sequence();

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
